### src/rlr_pkg.sv
// ----------------------------------------------------------------------------
// rlr_pkg: shared types and constants for the row RLE image decoder
//
// Holds the input and result item layouts, the configuration register
// indexes and the record that carries the results of one input byte.
// ----------------------------------------------------------------------------
package rlr_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH         = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT         = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPARENT_INDEX = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] ROW_WIDTH_RESET         = 16'd64;
  localparam logic [15:0] ROW_COUNT_RESET         = 16'd64;
  localparam logic [7:0]  TRANSPARENT_INDEX_RESET = 8'd0;

  // One byte of the compressed frame stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  // One pixel run.
  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [15:0] run_length;
    logic        row_end;
    logic        frame_end;
    logic        error;
    logic        last_of_item;
  } out_item_t;

  // Live configuration seen by the decoder.
  typedef struct packed {
    logic [15:0] row_width;
    logic [15:0] row_count;
    logic [7:0]  transparent_index;
  } cfg_t;

  // Up to two runs caused by one input byte, in output order.
  typedef struct packed {
    out_item_t   item0;
    out_item_t   item1;
    logic [1:0]  count;
  } batch_t;

endpackage

### src/rlr_decode.sv
// ----------------------------------------------------------------------------
// rlr_decode: row and control byte decoder
//
// Holds the row parsing state and turns each accepted stream byte into zero,
// one or two pixel runs, including the tail padding and the error result.
// ----------------------------------------------------------------------------
module rlr_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  rlr_pkg::in_item_t in_data,
  input  rlr_pkg::cfg_t     cfg,
  output rlr_pkg::batch_t   batch
);
  import rlr_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_CTRL,
    PH_REPEAT,
    PH_LITERAL,
    PH_DONE
  } phase_t;

  phase_t      phase;
  logic [7:0]  length_low_byte;
  logic [15:0] compressed_length;
  logic [15:0] bytes_consumed;
  logic [15:0] pixels_written;
  logic [6:0]  literals_left;
  logic [15:0] row_index;
  logic        frame_failed;

  phase_t      phase_next;
  logic [7:0]  length_low_byte_next;
  logic [15:0] compressed_length_next;
  logic [15:0] bytes_consumed_next;
  logic [15:0] pixels_written_next;
  logic [6:0]  literals_left_next;
  logic [15:0] row_index_next;
  logic        frame_failed_next;

  phase_t      eff_phase;
  logic        eff_failed;
  logic [15:0] eff_row;
  logic        active;
  logic        err;
  logic        check;
  logic        has_run;
  logic [7:0]  run_value;
  logic [15:0] run_len;
  logic [6:0]  data_cnt;
  logic [15:0] bc_inc;
  logic [16:0] pw_plus_skip;
  logic [16:0] pw_plus_data;
  logic [16:0] bc_plus_one;
  logic [16:0] bc_plus_data;
  logic        row_done;
  logic [15:0] pad_len;
  logic        pad_run;
  logic [15:0] row_inc;
  logic        frame_done;
  out_item_t   run_item;
  out_item_t   pad_item;
  out_item_t   err_item;

  // Decode of the current byte against the row state.
  always_comb begin
    eff_phase  = in_data.frame_start ? PH_LEN_LO : phase;
    eff_failed = in_data.frame_start ? 1'b0 : frame_failed;
    eff_row    = in_data.frame_start ? 16'd0 : row_index;
    active     = !eff_failed && (eff_phase != PH_DONE);

    data_cnt     = {1'b0, in_data.data_byte[7:2]} + 7'd1;
    bc_inc       = bytes_consumed + 16'd1;
    pw_plus_skip = {1'b0, pixels_written} + {10'd0, in_data.data_byte[7:1]};
    pw_plus_data = {1'b0, pixels_written} + {10'd0, data_cnt};
    bc_plus_one  = {1'b0, bc_inc} + 17'd1;
    bc_plus_data = {1'b0, bc_inc} + {10'd0, data_cnt};

    phase_next             = eff_phase;
    length_low_byte_next   = length_low_byte;
    compressed_length_next = compressed_length;
    bytes_consumed_next    = bytes_consumed;
    pixels_written_next    = pixels_written;
    literals_left_next     = literals_left;
    err       = 1'b0;
    check     = 1'b0;
    has_run   = 1'b0;
    run_value = 8'd0;
    run_len   = 16'd0;

    if (active) begin
      case (eff_phase)
        PH_LEN_LO: begin
          length_low_byte_next = in_data.data_byte;
          phase_next           = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          compressed_length_next = {in_data.data_byte, length_low_byte};
          bytes_consumed_next    = 16'd0;
          pixels_written_next    = 16'd0;
          literals_left_next     = 7'd0;
          phase_next             = PH_CTRL;
          check                  = 1'b1;
        end
        PH_CTRL: begin
          bytes_consumed_next = bc_inc;
          if (in_data.data_byte[0]) begin
            // Transparent skip run.
            if (pw_plus_skip > {1'b0, cfg.row_width}) begin
              err = 1'b1;
            end else begin
              has_run             = (in_data.data_byte[7:1] != 7'd0);
              run_value           = cfg.transparent_index;
              run_len             = {9'd0, in_data.data_byte[7:1]};
              pixels_written_next = pw_plus_skip[15:0];
              check               = 1'b1;
            end
          end else if (in_data.data_byte[1]) begin
            // Repeat of the next byte.
            if ((bc_plus_one > {1'b0, compressed_length}) ||
                (pw_plus_data > {1'b0, cfg.row_width})) begin
              err = 1'b1;
            end else begin
              literals_left_next = data_cnt;
              phase_next         = PH_REPEAT;
            end
          end else begin
            // Copy of literal bytes.
            if ((bc_plus_data > {1'b0, compressed_length}) ||
                (pw_plus_data > {1'b0, cfg.row_width})) begin
              err = 1'b1;
            end else begin
              literals_left_next = data_cnt;
              phase_next         = PH_LITERAL;
            end
          end
        end
        PH_REPEAT: begin
          bytes_consumed_next = bc_inc;
          has_run             = 1'b1;
          run_value           = in_data.data_byte;
          run_len             = {9'd0, literals_left};
          pixels_written_next = pixels_written + {9'd0, literals_left};
          literals_left_next  = 7'd0;
          phase_next          = PH_CTRL;
          check               = 1'b1;
        end
        PH_LITERAL: begin
          bytes_consumed_next = bc_inc;
          has_run             = 1'b1;
          run_value           = in_data.data_byte;
          run_len             = 16'd1;
          pixels_written_next = pixels_written + 16'd1;
          literals_left_next  = literals_left - 7'd1;
          if (literals_left == 7'd1) begin
            phase_next = PH_CTRL;
            check      = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Row end: width filled or compressed bytes used up.
    row_done = check && !((bytes_consumed_next < compressed_length_next) &&
                          (pixels_written_next < cfg.row_width));
    pad_len  = (pixels_written_next < cfg.row_width) ?
               (cfg.row_width - pixels_written_next) : 16'd0;
    pad_run  = row_done && ((pad_len != 16'd0) || !has_run);
    row_inc    = eff_row + 16'd1;
    frame_done = (row_inc >= cfg.row_count) || (row_inc == 16'd0);
    row_index_next = row_done ? row_inc : eff_row;
    if (row_done) begin
      phase_next = frame_done ? PH_DONE : PH_LEN_LO;
    end
    frame_failed_next = eff_failed || err;

    // Result records.
    run_item.pixel_value  = run_value;
    run_item.run_length   = run_len;
    run_item.row_end      = row_done && !pad_run;
    run_item.frame_end    = row_done && !pad_run && frame_done;
    run_item.error        = 1'b0;
    run_item.last_of_item = !pad_run;

    pad_item.pixel_value  = cfg.transparent_index;
    pad_item.run_length   = pad_len;
    pad_item.row_end      = 1'b1;
    pad_item.frame_end    = frame_done;
    pad_item.error        = 1'b0;
    pad_item.last_of_item = 1'b1;

    err_item.pixel_value  = 8'd0;
    err_item.run_length   = 16'd0;
    err_item.row_end      = 1'b0;
    err_item.frame_end    = 1'b0;
    err_item.error        = 1'b1;
    err_item.last_of_item = 1'b1;

    batch.item0 = pad_item;
    batch.item1 = pad_item;
    batch.count = 2'd0;
    if (err) begin
      batch.item0 = err_item;
      batch.count = 2'd1;
    end else if (has_run) begin
      batch.item0 = run_item;
      batch.count = pad_run ? 2'd2 : 2'd1;
    end else if (pad_run) begin
      batch.count = 2'd1;
    end
  end

  // Row state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEN_LO;
      length_low_byte   <= 8'd0;
      compressed_length <= 16'd0;
      bytes_consumed    <= 16'd0;
      pixels_written    <= 16'd0;
      literals_left     <= 7'd0;
      row_index         <= 16'd0;
      frame_failed      <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      length_low_byte   <= length_low_byte_next;
      compressed_length <= compressed_length_next;
      bytes_consumed    <= bytes_consumed_next;
      pixels_written    <= pixels_written_next;
      literals_left     <= literals_left_next;
      row_index         <= row_index_next;
      frame_failed      <= frame_failed_next;
    end
  end

  // A two-run transaction always ends in the padding run.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (accept && batch.count == 2'd2) |->
      (batch.item1.last_of_item && batch.item1.row_end && !batch.item0.last_of_item))
    else $error("two-run result not ordered run then padding");

  // An error result drops the rest of the frame.
  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    (accept && active && err) |=> frame_failed)
    else $error("error result did not mark the frame failed");

  // A failed or finished frame is silent until the next frame start.
  a_silent_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_data.frame_start && (frame_failed || phase == PH_DONE)) |->
      (batch.count == 2'd0))
    else $error("results produced after frame end or failure");

  // A pending repeat or literal run always has a nonzero count.
  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_REPEAT || phase == PH_LITERAL) |-> (literals_left != 7'd0))
    else $error("repeat or literal phase with zero count");

endmodule

### src/rlr_out_buf.sv
// ----------------------------------------------------------------------------
// rlr_out_buf: two-entry result buffer
//
// Registers the runs of one input byte and hands them out one per cycle while out_ready is high.
// A new transaction is loaded as soon as the last held run leaves.
// ----------------------------------------------------------------------------
module rlr_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  rlr_pkg::batch_t    batch,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rlr_pkg::out_item_t out_data
);
  import rlr_pkg::*;

  out_item_t  slot0;
  out_item_t  slot1;
  logic [1:0] cnt;
  logic       load;
  logic       pop;

  // Handshake decode.
  assign out_valid = (cnt != 2'd0);
  assign out_data  = slot0;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign load      = accept && (batch.count != 2'd0);

  // Result slots and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      slot0 <= batch.item0;
      slot1 <= batch.item1;
      cnt   <= batch.count;
    end else if (pop) begin
      slot0 <= slot1;
      cnt   <= cnt - 2'd1;
    end
  end

  // A full buffer holds a transaction's two runs in order.
  a_full_order: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> (slot1.last_of_item && !slot0.last_of_item))
    else $error("buffered runs out of order");

  // Taking the first of two runs exposes the second next.
  a_shift: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && pop) |=> (out_valid && out_data == $past(slot1)))
    else $error("second run lost after shift");

endmodule

### src/rle_row_image_decoder.sv
// ----------------------------------------------------------------------------
// rle_row_image_decoder: row run-length image decoder with transparent skips
//
// Decodes a compressed frame byte stream into pixel runs (value, count).
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   in_data   (data_byte, frame_start)
//   out      output     out_valid / out_ready out_data  (one pixel run)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A byte with at most one run is taken every cycle while out_ready is high; a
// two-run byte holds input until the single output port has drained its first
// run of the two-entry buffer. Results appear the cycle after a byte is taken.
// Reset is synchronous: width and row count return to 64, the transparent
// index to 0, and the first byte is taken as a row length.
// With out_ready low, input stalls once the buffer holds a pending run.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module rle_row_image_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rlr_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rlr_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [15:0]                       cfg_data
);
  import rlr_pkg::*;

  cfg_t   cfg;
  batch_t batch;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width         <= ROW_WIDTH_RESET;
      cfg.row_count         <= ROW_COUNT_RESET;
      cfg.transparent_index <= TRANSPARENT_INDEX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_WIDTH:         cfg.row_width         <= cfg_data;
        CFG_ROW_COUNT:         cfg.row_count         <= cfg_data;
        CFG_TRANSPARENT_INDEX: cfg.transparent_index <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rlr_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg),
    .batch   (batch)
  );

  rlr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .batch     (batch),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/rle_row_image_decoder_test.sv
// ----------------------------------------------------------------------------
// rle_row_image_decoder_test: self-checking bench for the row RLE decoder
//
// Drives compressed frame bytes into the decoder and predicts every pixel
// run from a behavioral copy of the row parser. Directed sequences cover the
// run kinds, padding, empty rows, malformed rows and register extremes; a
// long random part follows with mostly well-formed frames, some broken rows
// and noise, with random gaps on both channels.
// ----------------------------------------------------------------------------
module rle_row_image_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES  = 1450;
  localparam int unsigned STEADY_BYTES  = 150;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam longint      RUN_LIMIT_NS  = 4_000_000;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  // Row parser states of the predictor.
  typedef enum logic [2:0] {
    ST_LEN_LO, ST_LEN_HI, ST_CTRL, ST_REPEAT, ST_LITERAL, ST_DONE
  } parse_state_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  rle_row_image_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the row parser.
  logic [15:0] width_reg;
  logic [15:0] rows_reg;
  logic [7:0] transp_reg;
  parse_state_t parse_state;
  logic [7:0] len_lo;
  logic [15:0] comp_len;
  logic [15:0] consumed;
  logic [15:0] pix_count;
  logic [6:0] lits_left;
  logic [15:0] row_idx;
  logic frame_bad;

  out_item_t byte_runs[$];
  out_item_t expected_runs[$];
  logic [7:0] frame_bytes[$];
  int unsigned sent_bytes = 0;
  int unsigned fail_count = 0;
  int unsigned stall_left = 0;
  bit steady = 1'b0;

  task automatic reset_model();
    width_reg   = ROW_WIDTH_RESET;
    rows_reg    = ROW_COUNT_RESET;
    transp_reg  = TRANSPARENT_INDEX_RESET;
    parse_state = ST_LEN_LO;
    len_lo      = '0;
    comp_len    = '0;
    consumed    = '0;
    pix_count   = '0;
    lits_left   = '0;
    row_idx     = '0;
    frame_bad   = 1'b0;
  endtask

  function automatic out_item_t make_run(input logic [7:0] value, input logic [15:0] len);
    out_item_t r;
    r = '0;
    r.pixel_value = value;
    r.run_length  = len;
    return r;
  endfunction

  task automatic flag_error();
    out_item_t r;
    r = '0;
    r.error = 1'b1;
    byte_runs.insert(byte_runs.size(), r);
    frame_bad = 1'b1;
  endtask

  // Ends the row once the width is filled or the compressed bytes are used up,
  // padding the tail with transparent pixels.
  task automatic close_row();
    logic [15:0] pad;
    out_item_t r;
    if (consumed < comp_len && pix_count < width_reg) return;
    pad = (pix_count < width_reg) ? width_reg - pix_count : 16'd0;
    if (pad != 16'd0 || byte_runs.size() == 0)
      byte_runs.insert(byte_runs.size(), make_run(transp_reg, pad));
    r = byte_runs.pop_back();
    r.row_end = 1'b1;
    row_idx = row_idx + 16'd1;
    if (row_idx >= rows_reg || row_idx == 16'd0) begin
      r.frame_end = 1'b1;
      parse_state = ST_DONE;
    end else begin
      parse_state = ST_LEN_LO;
    end
    byte_runs.insert(byte_runs.size(), r);
  endtask

  // Works out the runs caused by one stream byte and queues them.
  task automatic decode_byte(input in_item_t item);
    logic [7:0] b;
    int unsigned cnt;
    out_item_t r;
    b = item.data_byte;
    byte_runs.delete();
    if (item.frame_start) begin
      row_idx = '0;
      frame_bad = 1'b0;
      parse_state = ST_LEN_LO;
    end
    if (frame_bad || parse_state == ST_DONE) return;
    case (parse_state)
      ST_LEN_LO: begin
        len_lo = b;
        parse_state = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        comp_len = {b, len_lo};
        consumed = '0;
        pix_count = '0;
        lits_left = '0;
        parse_state = ST_CTRL;
        close_row();
      end
      ST_CTRL: begin
        consumed = consumed + 16'd1;
        if (b[0]) begin
          // Transparent skip; an empty skip emits nothing.
          cnt = b[7:1];
          if (pix_count + cnt > width_reg) begin
            flag_error();
          end else begin
            if (cnt != 0)
              byte_runs.insert(byte_runs.size(), make_run(transp_reg, cnt[15:0]));
            pix_count = pix_count + cnt[15:0];
            close_row();
          end
        end else begin
          cnt = b[7:2] + 32'd1;
          if ((b[1] ? consumed + 32'd1 : consumed + cnt) > comp_len ||
              pix_count + cnt > width_reg) begin
            flag_error();
          end else begin
            lits_left = cnt[6:0];
            if (b[1]) parse_state = ST_REPEAT;
            else parse_state = ST_LITERAL;
          end
        end
      end
      ST_REPEAT: begin
        consumed = consumed + 16'd1;
        byte_runs.insert(byte_runs.size(), make_run(b, {9'd0, lits_left}));
        pix_count = pix_count + {9'd0, lits_left};
        lits_left = '0;
        parse_state = ST_CTRL;
        close_row();
      end
      ST_LITERAL: begin
        consumed = consumed + 16'd1;
        byte_runs.insert(byte_runs.size(), make_run(b, 16'd1));
        pix_count = pix_count + 16'd1;
        lits_left = lits_left - 7'd1;
        if (lits_left == 7'd0) begin
          parse_state = ST_CTRL;
          close_row();
        end
      end
      default: ;
    endcase
    if (byte_runs.size() > 0) begin
      r = byte_runs.pop_back();
      r.last_of_item = 1'b1;
      byte_runs.insert(byte_runs.size(), r);
    end
    foreach (byte_runs[i]) expected_runs.insert(expected_runs.size(), byte_runs[i]);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_run(input out_item_t got);
    out_item_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch("run_length of a run nobody expected", got.run_length, 0);
      return;
    end
    want = expected_runs.pop_front();
    if (got.pixel_value !== want.pixel_value)
      report_mismatch("pixel_value", got.pixel_value, want.pixel_value);
    if (got.run_length !== want.run_length)
      report_mismatch("run_length", got.run_length, want.run_length);
    if (got.row_end !== want.row_end)
      report_mismatch("row_end", got.row_end, want.row_end);
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", got.frame_end, want.frame_end);
    if (got.error !== want.error)
      report_mismatch("error", got.error, want.error);
    if (got.last_of_item !== want.last_of_item)
      report_mismatch("last_of_item", got.last_of_item, want.last_of_item);
  endtask

  // Watch every transaction at the rising edge: register writes, stream bytes
  // and pixel runs.
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_runs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_WIDTH:         width_reg = cfg_data;
          CFG_ROW_COUNT:         rows_reg = cfg_data;
          CFG_TRANSPARENT_INDEX: transp_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        sent_bytes++;
      end
      if (out_valid && out_ready) check_run(out_data);
    end
  end

  // Run receiver: random stall bursts, none in steady mode.
  always @(negedge clk) begin
    if (rst || steady) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic start);
    in_item_t item;
    item.data_byte = value;
    item.frame_start = start;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_input(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Holds off the sender until every predicted run has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] width, input logic [15:0] rows,
                           input logic [7:0] transp);
    write_reg(CFG_ROW_WIDTH, width);
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_TRANSPARENT_INDEX, {8'd0, transp});
  endtask

  // Sends the bytes in frame_bytes; the first one may restart the frame, and
  // noisy streams also get stray frame starts.
  task automatic send_frame(input bit restart, input bit noisy);
    logic start;
    foreach (frame_bytes[i]) begin
      if (!steady && $urandom_range(0, 7) == 0) pause_input($urandom_range(1, 9));
      if (i == 0) start = restart;
      else start = noisy && ($urandom_range(0, 15) == 0);
      send_byte(frame_bytes[i], start);
    end
  endtask

  // Appends one row: length header, then skip, repeat and literal runs with
  // random content. A broken row gets a short length or a corrupted byte.
  task automatic build_row(input int unsigned width, input bit broken);
    logic [7:0] body[$];
    int unsigned left;
    int unsigned cnt;
    int unsigned code;
    int unsigned len;
    left = width;
    while (left > 0 && $urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 2))
        0: begin
          cnt = $urandom_range(0, left < 127 ? left : 127);
          body.insert(body.size(), {cnt[6:0], 1'b1});
        end
        1: begin
          cnt = $urandom_range(1, left < 64 ? left : 64);
          code = cnt - 1;
          body.insert(body.size(), {code[5:0], 2'b10});
          body.insert(body.size(), 8'($urandom_range(0, 255)));
        end
        default: begin
          cnt = $urandom_range(1, left < 64 ? left : 64);
          code = cnt - 1;
          body.insert(body.size(), {code[5:0], 2'b00});
          repeat (cnt) body.insert(body.size(), 8'($urandom_range(0, 255)));
        end
      endcase
      left = left - cnt;
    end
    len = body.size();
    // Spare length after a full row is never read.
    if (left == 0 && $urandom_range(0, 3) == 0) len = len + $urandom_range(1, 5);
    if (broken && body.size() > 0) begin
      if ($urandom_range(0, 1) == 0) len = $urandom_range(0, body.size());
      else body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
    end
    frame_bytes.insert(frame_bytes.size(), len[7:0]);
    frame_bytes.insert(frame_bytes.size(), len[15:8]);
    foreach (body[i]) frame_bytes.insert(frame_bytes.size(), body[i]);
  endtask

  task automatic build_frame(input int unsigned rows, input int unsigned width, input bit rough);
    frame_bytes.delete();
    repeat (rows) build_row(width, rough && $urandom_range(0, 7) == 0);
  endtask

  // First byte after reset is a row length even without a frame start; the
  // row runs out of compressed bytes and is padded at its tail.
  task automatic test_reset_defaults();
    frame_bytes = '{8'h03, 8'h00, 8'h0B, 8'h06, 8'hFF};
    send_frame(1'b0, 1'b0);
    wait_drained();
  endtask

  // Empty skip, literals, a repeat that fills the row, an empty row that ends
  // the frame, and a byte ignored after the frame end.
  task automatic test_run_kinds();
    configure(16'd8, 16'd2, 8'hA5);
    frame_bytes = '{8'h06, 8'h00, 8'h01, 8'h04, 8'h00, 8'hFF, 8'h16, 8'h7F,
                    8'h00, 8'h00, 8'h3C};
    send_frame(1'b1, 1'b0);
    wait_drained();
  endtask

  // Largest width, rows and length; longest skip and repeat; the width is
  // lowered under an open literal run so the row ends with no padding.
  task automatic test_extremes();
    configure(16'hFFFF, 16'hFFFF, 8'hFF);
    frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h80, 8'h0C, 8'h11, 8'h22};
    send_frame(1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_ROW_WIDTH, 16'd100);
    write_reg(CFG_UNUSED, 16'hFFFF);
    frame_bytes = '{8'h33, 8'h44};
    send_frame(1'b0, 1'b0);
    wait_drained();
  endtask

  // Zero width and zero rows: a zero-length transparent run ends row and frame.
  task automatic test_zero_sizes();
    configure(16'd0, 16'd0, 8'h5A);
    frame_bytes = '{8'h05, 8'h00, 8'h42};
    send_frame(1'b1, 1'b0);
    wait_drained();
  endtask

  // Each kind of malformed control byte; the rest of the frame is dropped.
  task automatic test_malformed_rows();
    configure(16'd8, 16'd3, 8'h0F);
    frame_bytes = '{8'h02, 8'h00, 8'h13, 8'h55};
    send_frame(1'b1, 1'b0);
    frame_bytes = '{8'h01, 8'h00, 8'h02};
    send_frame(1'b1, 1'b0);
    frame_bytes = '{8'h05, 8'h00, 8'h22};
    send_frame(1'b1, 1'b0);
    frame_bytes = '{8'h03, 8'h00, 8'h08};
    send_frame(1'b1, 1'b0);
    frame_bytes = '{8'h0A, 8'h00, 8'h20};
    send_frame(1'b1, 1'b0);
    wait_drained();
  endtask

  // Mostly well-formed frames under changing settings, with broken rows,
  // trailing bytes after the frame end and pure noise mixed in.
  task automatic test_random_frames();
    int unsigned frames;
    int unsigned width;
    int unsigned rows;
    frames = 0;
    width = 1;
    rows = 1;
    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      if (frames % 6 == 0) begin
        wait_drained();
        case ($urandom_range(0, 9))
          0: width = 1;
          1, 2: width = $urandom_range(49, 300);
          default: width = $urandom_range(1, 48);
        endcase
        rows = $urandom_range(1, 5);
        configure(width[15:0], rows[15:0], 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        frame_bytes.delete();
        repeat ($urandom_range(3, 16))
          frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
        send_frame(1'b1, 1'b1);
      end else begin
        build_frame(rows, width, 1'b1);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3))
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
        send_frame(1'b1, 1'b0);
      end
      if (frames == 1 || $urandom_range(0, 9) == 0) wait_drained();
      frames++;
    end
  endtask

  // Back-to-back clean frames with both sides always ready.
  task automatic test_steady_stream();
    int unsigned start_count;
    wait_drained();
    configure(16'd24, 16'd3, 8'h33);
    steady = 1'b1;
    start_count = sent_bytes;
    while (sent_bytes - start_count < STEADY_BYTES) begin
      build_frame(3, 24, 1'b0);
      send_frame(1'b1, 1'b0);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROW_WIDTH;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_run_kinds();
    test_extremes();
    test_zero_sizes();
    test_malformed_rows();
    test_random_frames();
    test_steady_stream();
    wait_drained();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
